// ===== sv/ofb64_pkg.sv =====
// ----------------------------------------------------------------------------
// ofb64_pkg
// Shared types and constants of the offset base64 frame encoder: command
// codes, frame characters and the job record passed from front to back.
// ----------------------------------------------------------------------------
package ofb64_pkg;

   // Input command codes
   localparam logic [1:0] CMD_BEGIN   = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD = 2'd1;
   localparam logic [1:0] CMD_FINISH  = 2'd2;

   // Frame characters
   localparam logic [7:0] CHAR_OFFSET = 8'h3D;  // '='
   localparam logic [7:0] CHAR_START  = 8'h23;  // '#'
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // Character index inside one job; finish without a group starts at four
   typedef logic [2:0] step_type;
   localparam step_type STEP_BEGIN_LAST  = 3'd2;
   localparam step_type STEP_GROUP_LAST  = 3'd3;
   localparam step_type STEP_SUM_HIGH    = 3'd4;
   localparam step_type STEP_SUM_LOW     = 3'd5;
   localparam step_type STEP_FINISH_LAST = 3'd6;

   typedef logic [11:0] sum_type;

   typedef enum logic [1:0] {
      JOB_BEGIN,
      JOB_GROUP,
      JOB_FINISH
   } job_kind_type;

   // One unit of output work; begin carries the message type in byte_a
   typedef struct packed {
      job_kind_type kind;
      logic         with_group;
      logic [7:0]   byte_a;
      logic [7:0]   byte_b;
      logic [7:0]   byte_c;
   } job_type;

endpackage

// ===== sv/ofb64_front.sv =====
// ----------------------------------------------------------------------------
// ofb64_front
// Request side: accepts requests, gathers payload bytes into groups of
// three and pushes begin, group and finish jobs into the job queue.
// ----------------------------------------------------------------------------
module ofb64_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_message_type,
   input  logic [7:0]       req_data_byte,
   input  logic             queue_full,
   output logic             push_valid,
   output ofb64_pkg::job_type push_job
);

   logic [1:0] group_pos_ff;
   logic [1:0] group_pos_in;
   logic [7:0] held_first_ff;
   logic [7:0] held_first_in;
   logic [7:0] held_second_ff;
   logic [7:0] held_second_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Classify the request and build its job
   always_comb begin
      push_valid          = 1'b0;
      push_job.kind       = ofb64_pkg::JOB_GROUP;
      push_job.with_group = 1'b1;
      push_job.byte_a     = held_first_ff;
      push_job.byte_b     = held_second_ff;
      push_job.byte_c     = req_data_byte;
      group_pos_in        = group_pos_ff;
      held_first_in       = held_first_ff;
      held_second_in      = held_second_ff;
      if (accept) begin
         unique case (req_command)
            ofb64_pkg::CMD_BEGIN: begin
               push_valid      = 1'b1;
               push_job.kind   = ofb64_pkg::JOB_BEGIN;
               push_job.byte_a = req_message_type;
               group_pos_in    = 2'd0;
            end
            ofb64_pkg::CMD_PAYLOAD: begin
               priority if (group_pos_ff == 2'd0) begin
                  held_first_in = req_data_byte;
                  group_pos_in  = 2'd1;
               end else if (group_pos_ff == 2'd1) begin
                  held_second_in = req_data_byte;
                  group_pos_in   = 2'd2;
               end else begin
                  push_valid   = 1'b1;
                  group_pos_in = 2'd0;
               end
            end
            ofb64_pkg::CMD_FINISH: begin
               push_valid          = 1'b1;
               push_job.kind       = ofb64_pkg::JOB_FINISH;
               push_job.with_group = (group_pos_ff != 2'd0);
               push_job.byte_b     = (group_pos_ff == 2'd2) ? held_second_ff : 8'd0;
               push_job.byte_c     = 8'd0;
               group_pos_in        = 2'd0;
            end
            default: begin
               // unused command: drop it
               push_valid = 1'b0;
            end
         endcase
      end
   end

   // Hold the open group
   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff <= 2'd0;
      end else begin
         group_pos_ff <= group_pos_in;
      end
      held_first_ff  <= held_first_in;
      held_second_ff <= held_second_in;
   end

endmodule

// ===== sv/ofb64_queue.sv =====
// ----------------------------------------------------------------------------
// ofb64_queue
// Short job queue between the request side and the character sequencer.
// Head is shown combinationally; DEPTH must be 2 or more (not checked here).
// ----------------------------------------------------------------------------
module ofb64_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  ofb64_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output ofb64_pkg::job_type head_job
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   ofb64_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid && !pop |-> !full)
      else $error("job pushed into a full queue");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= COUNT_W'(DEPTH)) && (!pop || head_valid))
      else $error("queue count out of range or pop while empty");

endmodule

// ===== sv/ofb64_back.sv =====
// ----------------------------------------------------------------------------
// ofb64_back
// Character sequencer: walks the head job one character per cycle unless
// stalled, keeps the running checksum and drives the response output register.
// ----------------------------------------------------------------------------
module ofb64_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         node_address,
   input  logic               head_valid,
   input  ofb64_pkg::job_type head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_frame_char,
   output logic               rsp_run_last
);

   ofb64_pkg::step_type step_ff;
   ofb64_pkg::step_type step_in;
   ofb64_pkg::step_type eff_step;
   ofb64_pkg::sum_type  sum_ff;
   ofb64_pkg::sum_type  sum_in;
   ofb64_pkg::sum_type  sum_base;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          rsp_char_ff;
   logic                rsp_last_ff;
   logic                load;
   logic [7:0]          next_char;
   logic                next_last;
   logic                add_to_sum;
   logic                clear_sum;

   // One six-bit piece of a three-byte group, offset into printable range
   function automatic logic [7:0] piece_char(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [1:0] idx);
      logic [5:0] piece;
      unique case (idx)
         2'd0:    piece = a[7:2];
         2'd1:    piece = {a[1:0], b[7:4]};
         2'd2:    piece = {b[3:0], c[7:6]};
         default: piece = c[5:0];
      endcase
      return {2'b00, piece} + ofb64_pkg::CHAR_OFFSET;
   endfunction

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && next_last;

   // Finish without a group skips the four group characters
   assign eff_step = (head_job.kind == ofb64_pkg::JOB_FINISH && !head_job.with_group)
                     ? step_ff + 3'd4 : step_ff;

   // Select the next character
   always_comb begin
      next_char  = piece_char(head_job.byte_a, head_job.byte_b, head_job.byte_c,
                              eff_step[1:0]);
      next_last  = 1'b0;
      add_to_sum = 1'b1;
      clear_sum  = 1'b0;
      sum_base   = sum_ff;
      unique case (head_job.kind)
         ofb64_pkg::JOB_BEGIN: begin
            next_last = (step_ff == ofb64_pkg::STEP_BEGIN_LAST);
            if (step_ff == 3'd0) begin
               next_char = ofb64_pkg::CHAR_START;
               sum_base  = '0;
            end else if (step_ff == 3'd1) begin
               next_char = node_address;
            end else begin
               next_char = head_job.byte_a;
            end
         end
         ofb64_pkg::JOB_GROUP: begin
            next_last = (step_ff == ofb64_pkg::STEP_GROUP_LAST);
         end
         ofb64_pkg::JOB_FINISH: begin
            priority if (eff_step == ofb64_pkg::STEP_SUM_HIGH) begin
               next_char  = {2'b00, sum_ff[11:6]} + ofb64_pkg::CHAR_OFFSET;
               add_to_sum = 1'b0;
            end else if (eff_step == ofb64_pkg::STEP_SUM_LOW) begin
               next_char  = {2'b00, sum_ff[5:0]} + ofb64_pkg::CHAR_OFFSET;
               add_to_sum = 1'b0;
            end else if (eff_step == ofb64_pkg::STEP_FINISH_LAST) begin
               next_char  = ofb64_pkg::CHAR_CR;
               next_last  = 1'b1;
               add_to_sum = 1'b0;
               clear_sum  = 1'b1;
            end else begin
               add_to_sum = 1'b1;
            end
         end
         default: begin
            next_last = 1'b1;
         end
      endcase
   end

   // Advance step and checksum
   always_comb begin
      step_in = step_ff;
      sum_in  = sum_ff;
      if (load) begin
         step_in = next_last ? '0 : step_ff + 1'b1;
         if (clear_sum) begin
            sum_in = '0;
         end else if (add_to_sum) begin
            sum_in = sum_base + {4'd0, next_char};
         end
      end
   end

   // Drop valid once taken, reload on a new character
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_char_ff <= next_char;
         rsp_last_ff <= next_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_char = rsp_char_ff;
   assign rsp_run_last   = rsp_last_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ofb64_pkg::STEP_FINISH_LAST)
      else $error("character step beyond end of job");

   a_cr_clears_sum: assert property (@(posedge clock) disable iff (reset)
      load && clear_sum |=> sum_ff == '0 && rsp_frame_char == ofb64_pkg::CHAR_CR
                             && rsp_run_last && step_ff == '0)
      else $error("carriage return did not close the frame");

endmodule

// ===== sv/offset_base64_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// offset_base64_frame_encoder
// Text frame encoder: begin, payload and finish requests in, one frame
// character per response out, with a sum checksum before the CR.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (req_*) carry a command: begin frame, payload byte or finish.
//   Responses (rsp_*) carry one character each; rsp_run_last marks the last
//   character produced by a request. csr_write_enable/csr_write_data set the
//   node address; the user writes it only while the block is idle (not enforced).
//   A request is taken when req_valid and req_ready are high; its job, if it
//   makes one, goes to a job queue of QUEUE_DEPTH entries, and the sequencer
//   loads each character of the head job into the output register.
//   The sequencer sends one character per cycle while it has a job and the
//   output does not stall: begin gives 3 characters, a payload byte closing a
//   group of three gives 4, finish gives 3 or 7; other payload bytes and unused
//   commands produce nothing and are taken back to back while the queue has
//   room. The output character rate sets the sustained throughput: 4 characters per 3 payload bytes.
//   Reset clears the queue, the open group and the checksum, drops
//   rsp_valid and sets the node address to 97.
//   When the receiver stalls the output register holds, the queue fills
//   and req_ready drops once it is full.
// ----------------------------------------------------------------------------
module offset_base64_frame_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_message_type,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_char,
   output logic       rsp_run_last,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam logic [7:0] NODE_ADDRESS_RESET = 8'd97;

   logic [7:0]         node_address_ff;
   logic [7:0]         node_address_in;
   logic               queue_full;
   logic               push_valid;
   ofb64_pkg::job_type push_job;
   logic               head_valid;
   ofb64_pkg::job_type head_job;
   logic               pop;

   // Node address register
   assign node_address_in = csr_write_enable ? csr_write_data : node_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= NODE_ADDRESS_RESET;
      end else begin
         node_address_ff <= node_address_in;
      end
   end

   ofb64_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_message_type (req_message_type),
      .req_data_byte    (req_data_byte),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   ofb64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ofb64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .node_address   (node_address_ff),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_char (rsp_frame_char),
      .rsp_run_last   (rsp_run_last)
   );

endmodule
